/* hw/rtl/assert_macros.svh */
// assertion helpers for the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CHECK_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");
`define CHECK_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define CHECK_PROP(label, prop)
`define CHECK_NEVER(label, cond)
`endif

`endif

/* hw/rtl/gmld_pkg.sv */
package gmld_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int VALUE_LIMIT = 1023;
  localparam int CELLS       = MAX_ROWS * MAX_COLS;
  localparam int SLOTS       = CELLS + 2;
  localparam int VALUE_DEPTH = VALUE_LIMIT + 1;

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 10;
  localparam int LINE_W  = 6;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W;
  localparam int CELL_W  = VAL_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_ROW = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_COL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FINISH,
    OP_DELETE,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  first;
    logic [LINE_W-1:0] stride;
    logic [LINE_W-1:0] count;
  } job_t;

endpackage

/* hw/rtl/gmld_ram.sv */
module gmld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gmld_front.sv */
module gmld_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gmld_pkg::CMD_W-1:0]  cmd,
  input  logic [gmld_pkg::VAL_W-1:0]  cell_value,
  input  logic [gmld_pkg::LINE_W-1:0] line_index,
  input  logic [gmld_pkg::LINE_W-1:0] rows_in_use,
  input  logic [gmld_pkg::LINE_W-1:0] cols_in_use,
  input  logic                        clearing,
  input  logic                        pop,
  output logic                        busy,
  output logic                        head_valid,
  output gmld_pkg::job_t              head
);
  import gmld_pkg::*;

  logic [LINE_W-1:0]   rows_eff, cols_eff, line_m1;
  logic [2*LINE_W-1:0] area, row_first;
  logic [CNT_W-1:0]    loaded, loaded_next;
  logic                finished, finished_next;
  logic                accept, push;
  job_t                job, q0, q1;
  logic [1:0]          qcnt;

  assign rows_eff  = (rows_in_use > LINE_W'(MAX_ROWS)) ? LINE_W'(MAX_ROWS) : rows_in_use;
  assign cols_eff  = (cols_in_use > LINE_W'(MAX_COLS)) ? LINE_W'(MAX_COLS) : cols_in_use;
  assign area      = rows_eff * cols_eff;
  assign line_m1   = line_index - LINE_W'(1);
  assign row_first = line_m1 * cols_eff;
  assign busy      = clearing || (qcnt == 2'd2);
  assign accept    = start && !busy;
  assign head_valid = (qcnt != 2'd0);
  assign head      = q0;

  always_comb begin
    push          = 1'b0;
    loaded_next   = loaded;
    finished_next = finished;
    job.op        = OP_QUERY;
    job.value     = cell_value;
    job.first     = row_first[CNT_W-1:0];
    job.stride    = LINE_W'(1);
    job.count     = cols_eff;
    if (accept) begin
      case (cmd)
        CMD_LOAD: begin
          if (!finished && {1'b0, loaded} < area) begin
            push        = 1'b1;
            job.op      = OP_LOAD;
            loaded_next = loaded + CNT_W'(1);
          end
        end
        CMD_FINISH: begin
          if (!finished) begin
            push          = 1'b1;
            job.op        = OP_FINISH;
            finished_next = 1'b1;
          end
        end
        CMD_DEL_ROW: begin
          if (finished && line_index != '0 && line_index <= rows_eff) begin
            push   = 1'b1;
            job.op = OP_DELETE;
          end
        end
        CMD_DEL_COL: begin
          if (finished && line_index != '0 && line_index <= cols_eff) begin
            push       = 1'b1;
            job.op     = OP_DELETE;
            job.first  = CNT_W'(line_m1);
            job.stride = cols_eff;
            job.count  = rows_eff;
          end
        end
        CMD_QUERY: begin
          if (finished) begin
            push   = 1'b1;
            job.op = OP_QUERY;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      finished <= 1'b0;
      qcnt     <= 2'd0;
    end else begin
      loaded   <= loaded_next;
      finished <= finished_next;
      qcnt     <= qcnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      q0 <= q1;
    end
    if (push) begin
      if ((qcnt - {1'b0, pop}) == 2'd0) begin
        q0 <= job;
      end else begin
        q1 <= job;
      end
    end
  end

endmodule

/* hw/rtl/gmld_back.sv */
module gmld_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  gmld_pkg::job_t             head,
  output logic                       pop,
  output logic                       clearing,
  output logic                       result_valid,
  output logic [gmld_pkg::VAL_W-1:0] median_value
);
  import gmld_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LD_WR, S_SRT_RD, S_SRT_CNT, S_SRT_EMIT,
    S_DEL_RD, S_DEL_CELL, S_DEL_LAST, S_DEL_LINK, S_DEL_MOVE, S_Q_OUT
  } state_t;

  localparam logic [VAL_W-1:0] VAL_LAST = VAL_W'(VALUE_DEPTH - 1);

  state_t            state, state_next;
  logic [VAL_W-1:0]  clr_addr, clr_addr_next, v, v_next, cur_v, cur_v_next;
  logic [CNT_W-1:0]  fill, fill_next, rem, rem_next, loaded, loaded_next;
  logic [CNT_W-1:0]  addr, addr_next, live, live_next;
  logic [SLOT_W-1:0] p, p_next, s, s_next, s_pred, s_pred_next, after, after_next;
  logic [SLOT_W-1:0] fill_inc;
  logic [LINE_W-1:0] stride, stride_next, left, left_next;
  logic              mv_next, mv_next_next, mv_prev, mv_prev_next;
  logic              rv_next;
  logic [VAL_W-1:0]  med_next;

  logic              cell_we, hist_we, last_we, sort_we, nxt_we, prv_we;
  logic [CELL_AW-1:0] cell_wa, cell_ra;
  logic [CELL_W-1:0] cell_wd, cell_rd;
  logic [VAL_W-1:0]  hist_wa, hist_ra, last_wa, last_ra;
  logic [CNT_W-1:0]  hist_wd, hist_rd;
  logic [SLOT_W-1:0] last_wd, last_rd;
  logic [SLOT_W-1:0] sort_wa, sort_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
  logic [VAL_W-1:0]  sort_wd, sort_rd;
  logic [SLOT_W-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

  assign clearing = (state == S_CLEAR);
  assign fill_inc = fill + SLOT_W'(1);

  gmld_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell (
    .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
    .raddr(cell_ra), .rdata(cell_rd));
  gmld_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
    .raddr(hist_ra), .rdata(hist_rd));
  gmld_ram #(.WIDTH(SLOT_W), .DEPTH(VALUE_DEPTH)) u_last (
    .clk(clk), .we(last_we), .waddr(last_wa), .wdata(last_wd),
    .raddr(last_ra), .rdata(last_rd));
  gmld_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_sort (
    .clk(clk), .we(sort_we), .waddr(sort_wa), .wdata(sort_wd),
    .raddr(sort_ra), .rdata(sort_rd));
  gmld_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .raddr(nxt_ra), .rdata(nxt_rd));
  gmld_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .raddr(prv_ra), .rdata(prv_rd));

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    v_next        = v;
    cur_v_next    = cur_v;
    fill_next     = fill;
    rem_next      = rem;
    loaded_next   = loaded;
    addr_next     = addr;
    live_next     = live;
    p_next        = p;
    s_next        = s;
    s_pred_next   = s_pred;
    after_next    = after;
    stride_next   = stride;
    left_next     = left;
    mv_next_next  = mv_next;
    mv_prev_next  = mv_prev;
    rv_next       = 1'b0;
    med_next      = median_value;
    pop           = 1'b0;
    cell_we = 1'b0; cell_wa = addr[CELL_AW-1:0]; cell_wd = {1'b1, cur_v};
    cell_ra = addr[CELL_AW-1:0];
    hist_we = 1'b0; hist_wa = cur_v; hist_wd = hist_rd + CNT_W'(1); hist_ra = v;
    last_we = 1'b0; last_wa = cur_v; last_wd = '0; last_ra = cur_v;
    sort_we = 1'b0; sort_wa = fill_inc; sort_wd = v; sort_ra = p;
    nxt_we  = 1'b0; nxt_wa = fill_inc; nxt_wd = fill_inc + SLOT_W'(1); nxt_ra = p;
    prv_we  = 1'b0; prv_wa = fill_inc; prv_wd = fill; prv_ra = p;

    case (state)
      S_CLEAR: begin
        hist_we       = 1'b1;
        hist_wa       = clr_addr;
        hist_wd       = '0;
        clr_addr_next = clr_addr + VAL_W'(1);
        if (clr_addr == VAL_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.op)
            OP_LOAD: begin
              cell_we     = 1'b1;
              cell_wa     = loaded[CELL_AW-1:0];
              cell_wd     = {1'b0, head.value};
              hist_ra     = head.value;
              cur_v_next  = head.value;
              loaded_next = loaded + CNT_W'(1);
              state_next  = S_LD_WR;
            end
            OP_FINISH: begin
              v_next     = '0;
              fill_next  = '0;
              state_next = S_SRT_RD;
            end
            OP_DELETE: begin
              addr_next   = head.first;
              stride_next = head.stride;
              left_next   = head.count;
              state_next  = (head.count == '0) ? S_IDLE : S_DEL_RD;
            end
            default: begin
              sort_ra    = p;
              state_next = S_Q_OUT;
            end
          endcase
        end
      end
      S_LD_WR: begin
        hist_we    = 1'b1;
        state_next = S_IDLE;
      end
      S_SRT_RD: begin
        state_next = S_SRT_CNT;
      end
      S_SRT_CNT: begin
        last_we = 1'b1;
        last_wa = v;
        last_wd = (hist_rd != '0) ? fill + hist_rd : '0;
        if (hist_rd != '0) begin
          rem_next   = hist_rd;
          state_next = S_SRT_EMIT;
        end else if (v == VAL_LAST) begin
          live_next  = fill;
          p_next     = fill_inc >> 1;
          state_next = S_IDLE;
        end else begin
          v_next     = v + VAL_W'(1);
          state_next = S_SRT_RD;
        end
      end
      S_SRT_EMIT: begin
        sort_we   = 1'b1;
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        fill_next = fill_inc;
        rem_next  = rem - CNT_W'(1);
        if (rem == CNT_W'(1)) begin
          if (v == VAL_LAST) begin
            live_next  = fill_inc;
            p_next     = (fill_inc + SLOT_W'(1)) >> 1;
            state_next = S_IDLE;
          end else begin
            v_next     = v + VAL_W'(1);
            state_next = S_SRT_RD;
          end
        end
      end
      S_DEL_RD: begin
        state_next = S_DEL_CELL;
      end
      S_DEL_CELL: begin
        if (addr < loaded && !cell_rd[CELL_W-1]) begin
          cell_we    = 1'b1;
          cell_wd    = {1'b1, cell_rd[VAL_W-1:0]};
          last_ra    = cell_rd[VAL_W-1:0];
          cur_v_next = cell_rd[VAL_W-1:0];
          state_next = S_DEL_LAST;
        end else begin
          left_next  = left - LINE_W'(1);
          addr_next  = addr + CNT_W'(stride);
          state_next = (left == LINE_W'(1)) ? S_IDLE : S_DEL_RD;
        end
      end
      S_DEL_LAST: begin
        if (last_rd == '0 || live == '0) begin
          left_next  = left - LINE_W'(1);
          addr_next  = addr + CNT_W'(stride);
          state_next = (left == LINE_W'(1)) ? S_IDLE : S_DEL_RD;
        end else begin
          s_next     = last_rd;
          nxt_ra     = last_rd;
          prv_ra     = last_rd;
          sort_ra    = last_rd - SLOT_W'(1);
          state_next = S_DEL_LINK;
        end
      end
      S_DEL_LINK: begin
        s_pred_next  = prv_rd;
        after_next   = nxt_rd;
        last_we      = 1'b1;
        last_wd      = (s > SLOT_W'(1) && sort_rd == cur_v) ? s - SLOT_W'(1) : '0;
        mv_next_next = !live[0] && (s <= p);
        mv_prev_next = live[0] && (s >= p);
        state_next   = S_DEL_MOVE;
      end
      S_DEL_MOVE: begin
        if (mv_next) begin
          p_next = nxt_rd;
        end else if (mv_prev) begin
          p_next = prv_rd;
        end
        live_next  = live - CNT_W'(1);
        nxt_we     = 1'b1;
        nxt_wa     = s_pred;
        nxt_wd     = after;
        prv_we     = 1'b1;
        prv_wa     = after;
        prv_wd     = s_pred;
        left_next  = left - LINE_W'(1);
        addr_next  = addr + CNT_W'(stride);
        state_next = (left == LINE_W'(1)) ? S_IDLE : S_DEL_RD;
      end
      S_Q_OUT: begin
        rv_next    = 1'b1;
        med_next   = (p == '0) ? '0 : sort_rd;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      loaded       <= '0;
      live         <= '0;
      p            <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      loaded       <= loaded_next;
      live         <= live_next;
      p            <= p_next;
      result_valid <= rv_next;
    end
    v            <= v_next;
    cur_v        <= cur_v_next;
    fill         <= fill_next;
    rem          <= rem_next;
    addr         <= addr_next;
    s            <= s_next;
    s_pred       <= s_pred_next;
    after        <= after_next;
    stride       <= stride_next;
    left         <= left_next;
    mv_next      <= mv_next_next;
    mv_prev      <= mv_prev_next;
    median_value <= med_next;
  end

endmodule

/* hw/rtl/grid_median_with_line_deletion_core.sv */
// Grid median with line deletion.
// Commands enter on start/cmd/cell_value/line_index; a transfer happens on a
// rising edge with start high and busy low. Loads fill the grid row by row,
// finish sorts the loaded values, delete row/column removes live cells and
// query returns the lower median on median_value with result_valid high for
// one cycle; the receiver cannot stall it.
// Geometry is set through the APB port: rows_in_use at 0x0, cols_in_use at 0x4.
// A small command queue sits between the decoder and the executor, so up to
// two commands can be accepted while the executor is working.
// The executor steps each command through its own states: finish walks all
// 1024 value codes and writes one sorted slot per loaded cell; delete reads
// each cell of the line, skips gone or unloaded cells, marks the rest gone and
// unlinks the live sorted copy where there is one; the on-chip tables have a
// registered read port and a separate write port.
// After reset the histogram table is cleared with busy high; configuration
// writes are taken during that time.
`include "assert_macros.svh"

module grid_median_with_line_deletion_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gmld_pkg::CMD_W-1:0]  cmd,
  input  logic [gmld_pkg::VAL_W-1:0]  cell_value,
  input  logic [gmld_pkg::LINE_W-1:0] line_index,
  output logic                        result_valid,
  output logic [gmld_pkg::VAL_W-1:0]  median_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gmld_pkg::*;

  logic [LINE_W-1:0] rows_in_use, cols_in_use;
  logic              cfg_wr, clearing, pop, head_valid;
  job_t              head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[1:0] != 2'd0) ? 32'd0 :
                  {26'd0, (paddr[2] ? cols_in_use : rows_in_use)};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= LINE_W'(MAX_ROWS);
      cols_in_use <= LINE_W'(MAX_COLS);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cols_in_use <= pwdata[LINE_W-1:0];
      end else begin
        rows_in_use <= pwdata[LINE_W-1:0];
      end
    end
  end

  gmld_front u_front (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .cell_value(cell_value),
    .line_index(line_index), .rows_in_use(rows_in_use), .cols_in_use(cols_in_use),
    .clearing(clearing), .pop(pop), .busy(busy), .head_valid(head_valid),
    .head(head));

  gmld_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .clearing(clearing), .result_valid(result_valid), .median_value(median_value));

  `CHECK_PROP(a_result_pulse, result_valid |=> !result_valid)
  `CHECK_PROP(a_busy_after_reset, $fell(rst) |-> busy)
  `CHECK_NEVER(a_pop_while_clearing, pop && clearing)

endmodule
